// File: hw/rtl/fifo_with_indexed_discard_defines.svh
// assertion macros for the fifo with indexed discard
`ifndef FIFO_WITH_INDEXED_DISCARD_DEFINES_SVH
`define FIFO_WITH_INDEXED_DISCARD_DEFINES_SVH

// checked only out of reset
`define FWID_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FWID_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/fwid_pkg.sv
// package: types, codes and sizes of the fifo with indexed discard
`timescale 1ns / 1ps
`default_nettype none

package fwid_pkg;

    localparam int DEPTH   = 16;
    localparam int ELEM_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int ERR_W   = 2;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (OCC_W > POS_W) ? OCC_W : POS_W;
    localparam int IN_DATA_W  = ((ELEM_W + POS_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = ELEM_W + COUNT_W + 1 + ERR_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int IN_USER_W  = FUNC_W;

    localparam logic [FUNC_W-1:0] FUNC_ENQ     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DISCARD = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [ELEM_W-1:0] elem;
        logic [POS_W-1:0]         position;
    } op_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] head_elem;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        logic [ERR_W-1:0]         error;
    } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/fwid_in_stage.sv
// input register: unpacks a slave beat and holds it until the core takes it
`timescale 1ns / 1ps
`default_nettype none

module fwid_in_stage (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fwid_pkg::IN_DATA_W-1:0]  s_tdata,  // elem, position, zero pad
    input  wire logic [fwid_pkg::IN_USER_W-1:0]  s_tuser,  // func
    input  wire logic                            take,
    output logic                                 op_valid,
    output fwid_pkg::op_t                        op
);
    import fwid_pkg::*;

    logic in_valid_reg;
    logic in_valid_next;
    op_t  op_reg;
    op_t  op_next;
    logic accept;

    assign s_tready = !in_valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        op_next = op_reg;
        if (accept)
        begin
            op_next.func     = s_tuser[FUNC_W-1:0];
            op_next.elem     = s_tdata[ELEM_W-1:0];
            op_next.position = s_tdata[ELEM_W +: POS_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign op_valid = in_valid_reg;
    assign op       = op_reg;

endmodule

`default_nettype wire

// File: hw/rtl/fwid_core.sv
// queue storage: compacted slot row, occupancy and the per-beat result
`timescale 1ns / 1ps
`default_nettype none

module fwid_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire fwid_pkg::op_t op,
    output fwid_pkg::res_t     res
);
    import fwid_pkg::*;

    logic signed [ELEM_W-1:0] slot_reg  [DEPTH];
    logic signed [ELEM_W-1:0] slot_next [DEPTH];
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;
    logic                     do_enq;
    logic                     do_remove;
    logic [CMP_W-1:0]         rm_pos;
    logic [ERR_W-1:0]         err;

    // decode the operation against the current fill
    always_comb
    begin
        do_enq    = 1'b0;
        do_remove = 1'b0;
        rm_pos    = '0;
        err       = ERR_OK;
        unique case (op.func)
            FUNC_ENQ:
            begin
                if (occ_reg == OCC_W'(DEPTH))
                begin
                    err = ERR_FULL;
                end
                else
                begin
                    do_enq = 1'b1;
                end
            end
            FUNC_DEQ:
            begin
                if (occ_reg == '0)
                begin
                    err = ERR_EMPTY;
                end
                else
                begin
                    do_remove = 1'b1;
                end
            end
            FUNC_DISCARD:
            begin
                if (CMP_W'(op.position) >= CMP_W'(occ_reg))
                begin
                    err = ERR_RANGE;
                end
                else
                begin
                    do_remove = 1'b1;
                    rm_pos    = CMP_W'(op.position);
                end
            end
            default:
            begin
                err = ERR_OK;
            end
        endcase
    end

    // each slot either takes the new tail, closes up from its neighbour or holds
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (do_enq && (CMP_W'(i) == CMP_W'(occ_reg)))
            begin
                slot_next[i] = op.elem;
            end
            else if (do_remove && (CMP_W'(i) >= rm_pos) && (i + 1 < DEPTH))
            begin
                slot_next[i] = slot_reg[(i + 1) % DEPTH];
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (do_enq)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (do_remove)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (take)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    always_comb
    begin
        res.head_elem = (occ_next != '0) ? slot_next[0] : '0;
        res.count     = COUNT_W'(occ_next);
        res.is_empty  = (occ_next == '0);
        res.error     = err;
    end

endmodule

`default_nettype wire

// File: hw/rtl/fifo_with_indexed_discard.sv
// Bounded FIFO of signed 32-bit elements with enqueue, dequeue and discard at
// a position counted from the head; the entries behind a removed one close up
// so order is kept. Every slave beat gives exactly one master beat carrying the
// head element (zero when empty), the count, an empty flag and an error code
// (full on enqueue, empty on dequeue, position out of range); a failed
// operation leaves the queue untouched and an unused func code only reports
// status. One beat is taken per clock while the master side does not stall:
// the slot row is a register array that appends, removes the head or
// compacts around any position in one combinational update. An accepted
// beat reaches the master side through the input register, which feeds the
// result register through that update. While the master side stalls, one
// beat waits in each register and s_tready drops until the result beat
// leaves. The queue is empty after reset; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_indexed_discard (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [fwid_pkg::IN_DATA_W-1:0]   s_tdata,  // elem, position, zero pad
    input  wire logic [fwid_pkg::IN_USER_W-1:0]   s_tuser,  // func
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [fwid_pkg::OUT_DATA_W-1:0]       m_tdata   // head_elem, count, is_empty, error
);
    import fwid_pkg::*;

    `include "fifo_with_indexed_discard_defines.svh"

    logic op_valid;
    op_t  op;
    res_t res;
    logic take;
    logic m_valid_reg;
    logic m_valid_next;
    res_t m_res_reg;
    res_t m_res_next;

    // the result register frees up when empty or when its beat leaves
    assign take = op_valid && (!m_valid_reg || m_tready);

    fwid_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .take     (take),
        .op_valid (op_valid),
        .op       (op)
    );

    fwid_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .op    (op),
        .res   (res)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        m_res_next   = m_res_reg;
        if (take)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({m_res_reg.error, m_res_reg.is_empty,
                                   m_res_reg.count, m_res_reg.head_elem});

    `FWID_ASSERT_RST(a_empty_head_zero, (m_valid_reg && m_res_reg.is_empty) |-> (m_res_reg.head_elem == '0 && m_res_reg.count == '0), "empty result with nonzero head or count")
    `FWID_ASSERT_RST(a_full_err_count, (m_valid_reg && m_res_reg.error == ERR_FULL) |-> (m_res_reg.count == COUNT_W'(DEPTH)), "full error below depth")
    `FWID_ASSERT_RST(a_empty_err_flag, (m_valid_reg && m_res_reg.error == ERR_EMPTY) |-> m_res_reg.is_empty, "empty error on a non-empty queue")
    `FWID_ASSERT_ALWAYS(a_no_take_in_reset, !rst_n |=> !m_valid_reg, "result valid during reset")

endmodule

`default_nettype wire

// File: dv/fifo_with_indexed_discard_tb.sv
// self-checking testbench for the fifo with indexed discard: directed and random operation beats
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_indexed_discard_tb;
    import fwid_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 730;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PAD_W        = IN_DATA_W - ELEM_W - POS_W;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;  // elem, position, zero pad
    logic [IN_USER_W-1:0]  s_tuser  = '0;  // func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // head_elem, count, is_empty, error

    logic signed [ELEM_W-1:0] queue_slots [DEPTH];
    logic [COUNT_W-1:0]       queue_count = '0;
    res_t                     expected_status [$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  result_stall   = 0;
    bit  idle_on        = 1'b1;

    fifo_with_indexed_discard dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic res_t apply_op(logic [FUNC_W-1:0] func, logic signed [ELEM_W-1:0] elem,
                                      logic [POS_W-1:0] position);
        res_t r;
        logic [ERR_W-1:0] err;
        int i;
        err = ERR_OK;
        case (func) inside
            FUNC_ENQ:
            begin
                if (queue_count >= DEPTH)
                    err = ERR_FULL;
                else
                begin
                    queue_slots[queue_count] = elem;
                    queue_count = queue_count + 1'b1;
                end
            end
            FUNC_DEQ, FUNC_DISCARD:
            begin
                if (func == FUNC_DEQ && queue_count == 0)
                    err = ERR_EMPTY;
                else if (func == FUNC_DISCARD && {1'b0, position} >= queue_count)
                    err = ERR_RANGE;
                else
                begin
                    // close up the gap behind the removed entry
                    for (i = (func == FUNC_DEQ) ? 0 : int'(position); i + 1 < queue_count; i++)
                        queue_slots[i] = queue_slots[i + 1];
                    queue_count = queue_count - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.head_elem = (queue_count != 0) ? queue_slots[0] : '0;
        r.count     = queue_count;
        r.is_empty  = (queue_count == 0);
        r.error     = err;
        return r;
    endfunction

    function automatic logic [ELEM_W-1:0] pick_elem();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_op(logic [FUNC_W-1:0] func, logic [ELEM_W-1:0] elem,
                           logic [POS_W-1:0] position);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{PAD_W{1'b0}}, position, elem};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_status.push_back(apply_op(func, elem, position));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_empty_errors();
        send_op(FUNC_DEQ, pick_elem(), 4'd0);
        send_op(FUNC_DISCARD, pick_elem(), 4'd0);
        send_op(FUNC_DISCARD, pick_elem(), 4'd15);
        send_op(FUNC_UNUSED, pick_elem(), 4'd9);
    endtask

    task automatic test_fill_and_overflow();
        int i;
        send_op(FUNC_ENQ, 32'h8000_0000, 4'd0);
        send_op(FUNC_ENQ, 32'h7fff_ffff, 4'd15);
        send_op(FUNC_ENQ, 32'h0000_0000, 4'd5);
        send_op(FUNC_ENQ, 32'hffff_ffff, 4'd10);
        for (i = 4; i < DEPTH; i++)
            send_op(FUNC_ENQ, $urandom, 4'($urandom_range(0, 15)));
        send_op(FUNC_ENQ, 32'h1234_5678, 4'd0);
        send_op(FUNC_UNUSED, pick_elem(), 4'd15);
    endtask

    task automatic test_discard_cases();
        send_op(FUNC_DISCARD, pick_elem(), 4'd15);
        send_op(FUNC_DISCARD, pick_elem(), 4'd15);
        send_op(FUNC_DISCARD, pick_elem(), 4'd7);
        send_op(FUNC_DISCARD, pick_elem(), 4'd0);
        send_op(FUNC_DEQ, pick_elem(), 4'd3);
    endtask

    task automatic test_random_mix();
        int n;
        int phase;
        int roll;
        int enq_w;
        int deq_w;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  p;
        phase = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                phase   = $urandom_range(0, 2);
            end
            if (n % 150 == 149)
                wait_drained();
            enq_w = (phase == 0) ? 70 : (phase == 1) ? 25 : 45;
            deq_w = (phase == 0) ? 15 : (phase == 1) ? 40 : 25;
            roll  = $urandom_range(0, 99);
            p     = POS_W'($urandom_range(0, 15));
            if (roll < 4)
                f = FUNC_UNUSED;
            else if (roll < 8)
                f = FUNC_W'($urandom_range(0, 3));
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < enq_w)
                    f = FUNC_ENQ;
                else if (roll < enq_w + deq_w)
                    f = FUNC_DEQ;
                else
                begin
                    f = FUNC_DISCARD;
                    if (queue_count != 0 && $urandom_range(0, 9) != 0)
                        p = POS_W'($urandom_range(0, int'(queue_count) - 1));
                end
            end
            send_op(f, pick_elem(), p);
        end
    endtask

    always @(negedge clk)
    begin
        if (result_stall > 0)
        begin
            m_tready     <= 1'b0;
            result_stall <= result_stall - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            result_stall <= idle_on ? $urandom_range(0, 19) : 0;
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                res_t want;
                want = expected_status.pop_front();
                if (m_tdata[ELEM_W-1:0] !== want.head_elem)
                begin
                    $display("%0t: head_elem expected %0d actual %0d", $time,
                             want.head_elem, $signed(m_tdata[ELEM_W-1:0]));
                    mismatch_count++;
                end
                if (m_tdata[ELEM_W +: COUNT_W] !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time,
                             want.count, m_tdata[ELEM_W +: COUNT_W]);
                    mismatch_count++;
                end
                if (m_tdata[ELEM_W + COUNT_W] !== want.is_empty)
                begin
                    $display("%0t: is_empty expected %0b actual %0b", $time,
                             want.is_empty, m_tdata[ELEM_W + COUNT_W]);
                    mismatch_count++;
                end
                if (m_tdata[ELEM_W + COUNT_W + 1 +: ERR_W] !== want.error)
                begin
                    $display("%0t: error expected %0d actual %0d", $time,
                             want.error, m_tdata[ELEM_W + COUNT_W + 1 +: ERR_W]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_errors();
        test_fill_and_overflow();
        test_discard_cases();
        test_random_mix();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_status.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            if (expected_status.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         expected_status.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: fifo_with_indexed_discard.f
+incdir+hw/rtl
hw/rtl/fwid_pkg.sv
hw/rtl/fwid_in_stage.sv
hw/rtl/fwid_core.sv
hw/rtl/fifo_with_indexed_discard.sv
dv/fifo_with_indexed_discard_tb.sv
